// ----- design/ftab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftab_pkg : shared types and constants of the allocation table engine
// Widths, operation and status codes, register indexes and the item structs
// used by the table engine and its entry unit.
// ----------------------------------------------------------------------------
package ftab_pkg;

  // Table store size in bytes and the derived widths
  localparam int TABLE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(TABLE_BYTES);
  localparam int OFF_W       = 14;
  localparam int LIM_W       = ADDR_W + 1;
  localparam int CMP_W       = (OFF_W > LIM_W) ? OFF_W : LIM_W;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int CL_W      = 12;
  localparam int VAL_W     = 16;
  localparam int CUR_W     = 16;
  localparam int CC_W      = 12;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 12;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_LONG   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 1'b1;

  // Entry values
  localparam logic [VAL_W-1:0] EOC_MIN16 = 16'hFFF8;
  localparam logic [VAL_W-1:0] EOC_MIN12 = 16'h0FF8;
  localparam logic [VAL_W-1:0] EOC_SET16 = 16'hFFFF;
  localparam logic [VAL_W-1:0] EOC_SET12 = 16'h0FFF;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CL_W-1:0]   cluster;
    logic [VAL_W-1:0]  entry_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic             end_of_chain;
    logic [ST_W-1:0]  status;
  } out_item_t;

  // Entry unit answers for the current cluster
  typedef struct packed {
    logic              in_range;
    logic              end_cur;
    logic              end_ent;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [VAL_W-1:0]  entry;
    logic [7:0]        nb0;
    logic [7:0]        nb1;
  } ftab_ent_t;

endpackage

// ----- design/ftab_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftab_ram : generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/ftab_entry_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftab_entry_unit : entry address, range, extract and merge unit
// For the cluster in hand: byte offsets, range check, end-of-chain compares,
// entry extraction from the two table bytes and the merged bytes to write.
// ----------------------------------------------------------------------------
module ftab_entry_unit import ftab_pkg::*; (
  input  logic             fat16_i,
  input  logic [CC_W-1:0]  cc_i,
  input  logic [CUR_W-1:0] cur_i,
  input  logic [15:0]      word_i,
  input  logic [VAL_W-1:0] wval_i,
  output ftab_ent_t        ent_o
);

  logic [12:0]      c13;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] off1;
  logic [CUR_W-1:0] lim;
  logic [VAL_W-1:0] entry;

  // Byte offset: cluster*2 or cluster + cluster/2
  assign c13  = cur_i[12:0];
  assign off  = fat16_i ? {c13, 1'b0} : ({1'b0, c13} + {2'b00, c13[12:1]});
  assign off1 = off + OFF_W'(1);
  assign lim  = CUR_W'(cc_i) + CUR_W'(1);

  // Extract the entry from the little-endian word
  always_comb begin
    if (fat16_i) begin
      entry = word_i;
    end else if (cur_i[0]) begin
      entry = {4'h0, word_i[15:4]};
    end else begin
      entry = {4'h0, word_i[11:0]};
    end
  end

  // Range, end-of-chain and merged bytes
  always_comb begin
    ent_o.in_range = (cur_i >= CUR_W'(2)) && (cur_i <= lim) &&
                     (CMP_W'(off1) < CMP_W'(TABLE_BYTES));
    ent_o.end_cur  = fat16_i ? (cur_i >= EOC_MIN16) : (cur_i >= EOC_MIN12);
    ent_o.end_ent  = fat16_i ? (entry >= EOC_MIN16) : (entry >= EOC_MIN12);
    ent_o.addr0    = ADDR_W'(off);
    ent_o.addr1    = ADDR_W'(off1);
    ent_o.entry    = entry;
    if (fat16_i) begin
      ent_o.nb0 = wval_i[7:0];
      ent_o.nb1 = wval_i[15:8];
    end else if (cur_i[0]) begin
      ent_o.nb0 = {wval_i[3:0], word_i[3:0]};
      ent_o.nb1 = wval_i[11:4];
    end else begin
      ent_o.nb0 = wval_i[7:0];
      ent_o.nb1 = {word_i[15:12], wval_i[11:8]};
    end
  end

endmodule

// ----- design/fat12_fat16_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_fat16_table_engine : FAT12 / FAT16 allocation table engine
// Keeps the allocation table in a byte RAM and runs read entry, write entry,
// allocate and free chain under a small sequencer around one entry unit.
// ----------------------------------------------------------------------------
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+-----------------------
//  command   | in_i (func, cluster, entry_value)     | start high, busy low
//  result    | result_o (value, end_of_chain, status)| done_o, one cycle
//  config    | cfg_idx_i, cfg_wdata_i                | cfg_we_i, no wait
//
//  Each entry access is a two-byte read and, when the entry changes, a
//  two-byte write, all through the one RAM port pair. Allocate scans from
//  cluster 2 for a free entry, marks it and links it to a nonzero
//  predecessor; free zeroes the chain entry by entry. An out-of-range
//  cluster gives its status without a table access.
//  After reset a clearing pass zeroes every byte of the RAM; busy
//  stays high meanwhile. The receiver cannot stall: done_o lasts one cycle.
// ----------------------------------------------------------------------------
module fat12_fat16_table_engine import ftab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_i,
  output logic                 done_o,
  output out_item_t            result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_RD2   = 4'd5;
  localparam logic [3:0] S_EVAL  = 4'd6;
  localparam logic [3:0] S_WR0   = 4'd7;
  localparam logic [3:0] S_WR1   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Operation phases
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_PRED  = 3'd2;
  localparam logic [2:0] OP_SCAN  = 3'd3;
  localparam logic [2:0] OP_MARK  = 3'd4;
  localparam logic [2:0] OP_LINK  = 3'd5;
  localparam logic [2:0] OP_FREE  = 3'd6;

  logic [3:0]        state_q, state_d;
  logic [2:0]        op_q, op_d;
  logic [CUR_W-1:0]  cur_q, cur_d;
  logic [VAL_W-1:0]  wval_q, wval_d;
  logic [CL_W-1:0]   pred_q, pred_d;
  logic [12:0]       found_q, found_d;
  logic [CC_W-1:0]   count_q, count_d;
  logic [7:0]        b0_q, b0_d;
  logic [15:0]       word_q, word_d;
  logic [VAL_W-1:0]  res_q, res_d;
  logic              eoc_q, eoc_d;
  logic [ST_W-1:0]   st_q, st_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              fat16_q, fat16_d;
  logic [CC_W-1:0]   cc_q, cc_d;

  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  ftab_ent_t         ent;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign done_o   = (state_q == S_DONE);
  assign result_o = '{result_value: res_q, end_of_chain: eoc_q, status: st_q};

  ftab_entry_unit u_entry (
    .fat16_i (fat16_q),
    .cc_i    (cc_q),
    .cur_i   (cur_q),
    .word_i  (word_q),
    .wval_i  (wval_q),
    .ent_o   (ent)
  );

  ftab_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // RAM port steering: clearing pass, the two byte writes and the read address
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ent.addr0;
    ram_wdata = ent.nb0;
    ram_raddr = (state_q == S_RD1) ? ent.addr1 : ent.addr0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
      end
      S_WR0: begin
        ram_we = 1'b1;
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = ent.addr1;
        ram_wdata = ent.nb1;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    fat16_d = fat16_q;
    cc_d    = cc_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAT_TYPE: fat16_d = cfg_wdata_i[0];
        CFG_CLUSTERS: cc_d    = cfg_wdata_i[CC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cur_d   = cur_q;
    wval_d  = wval_q;
    pred_d  = pred_q;
    found_d = found_q;
    count_d = count_q;
    b0_d    = b0_q;
    word_d  = word_q;
    res_d   = res_q;
    eoc_d   = eoc_q;
    st_d    = st_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(TABLE_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cur_d   = CUR_W'(in_i.cluster);
          pred_d  = in_i.cluster;
          wval_d  = in_i.entry_value;
          count_d = '0;
          res_d   = '0;
          eoc_d   = 1'b0;
          st_d    = ST_OK;
          state_d = S_CHECK;
          case (in_i.func)
            FN_READ:  op_d = OP_READ;
            FN_WRITE: op_d = OP_WRITE;
            FN_ALLOC: op_d = OP_PRED;
            FN_FREE:  op_d = OP_FREE;
            default:  op_d = OP_READ;
          endcase
        end
      end
      S_CHECK: begin
        case (op_q)
          OP_READ, OP_WRITE: begin
            if (!ent.in_range) begin
              st_d    = ST_RANGE;
              state_d = S_DONE;
            end else begin
              state_d = S_RD0;
            end
          end
          OP_PRED: begin
            if ((cur_q != '0) && !ent.in_range) begin
              st_d    = ST_RANGE;
              state_d = S_DONE;
            end else begin
              cur_d = CUR_W'(2);
              op_d  = OP_SCAN;
            end
          end
          OP_SCAN: begin
            if (!ent.in_range) begin
              st_d    = ST_NOFREE;
              state_d = S_DONE;
            end else begin
              state_d = S_RD0;
            end
          end
          OP_FREE: begin
            res_d = VAL_W'(count_q);
            if ((cur_q < CUR_W'(2)) || ent.end_cur) begin
              state_d = S_DONE;
            end else if (!ent.in_range) begin
              st_d    = ST_RANGE;
              state_d = S_DONE;
            end else if (count_q >= cc_q) begin
              st_d    = ST_LONG;
              state_d = S_DONE;
            end else begin
              state_d = S_RD0;
            end
          end
          default: state_d = S_RD0;
        endcase
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        b0_d    = ram_rdata;
        state_d = S_RD2;
      end
      S_RD2: begin
        word_d  = {ram_rdata, b0_q};
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_WR0;
        case (op_q)
          OP_READ: begin
            res_d   = ent.entry;
            eoc_d   = ent.end_ent;
            state_d = S_DONE;
          end
          OP_SCAN: begin
            if (ent.entry == '0) begin
              found_d = cur_q[12:0];
              wval_d  = fat16_q ? EOC_SET16 : EOC_SET12;
              op_d    = OP_MARK;
            end else begin
              cur_d   = cur_q + CUR_W'(1);
              state_d = S_CHECK;
            end
          end
          OP_LINK: wval_d = VAL_W'(found_q);
          OP_FREE: wval_d = '0;
          default: begin
          end
        endcase
      end
      S_WR0: state_d = S_WR1;
      S_WR1: begin
        state_d = S_DONE;
        case (op_q)
          OP_MARK: begin
            res_d = VAL_W'(found_q);
            if (pred_q != '0) begin
              cur_d   = CUR_W'(pred_q);
              op_d    = OP_LINK;
              state_d = S_CHECK;
            end
          end
          OP_LINK: res_d = VAL_W'(found_q);
          OP_FREE: begin
            count_d = count_q + CC_W'(1);
            cur_d   = ent.entry;
            state_d = S_CHECK;
          end
          default: begin
          end
        endcase
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= OP_READ;
      clr_q   <= '0;
      fat16_q <= 1'b0;
      cc_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      clr_q   <= clr_d;
      fat16_q <= fat16_d;
      cc_q    <= cc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    wval_q  <= wval_d;
    pred_q  <= pred_d;
    found_q <= found_d;
    count_q <= count_d;
    b0_q    <= b0_d;
    word_q  <= word_d;
    res_q   <= res_d;
    eoc_q   <= eoc_d;
    st_q    <= st_d;
  end

  // Checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !done_o)
    else $error("item accepted but sequencer not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("sequencer did not return to idle after a result");

  a_eoc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.end_of_chain) |-> (result_o.status == ST_OK))
    else $error("end of chain reported with an error status");

  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CMP_W'(ram_waddr) < CMP_W'(TABLE_BYTES)))
    else $error("table write beyond the store");

  a_free_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0 && op_q == OP_FREE) |-> (count_q < cc_q))
    else $error("free walk passed the cluster count");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for the FAT12 / FAT16 allocation table engine
// Drives read, write, allocate and free-chain commands through the start/busy
// port under several table formats and cluster counts. A shadow copy of the
// table bytes predicts every result, and a monitor compares each done_o item
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ftab_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             in_i;
  logic                 done_o;
  out_item_t            result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  // Shadow of the table and of the registers
  logic [7:0]  fat_shadow [TABLE_BYTES];
  bit          fat16;
  int unsigned ncl;

  out_item_t      pending_res [$];
  int unsigned    mismatch_cnt;
  int unsigned    idle_pct;
  logic [CL_W-1:0] chain_head;
  logic [CL_W-1:0] chain_tail;

  fat12_fat16_table_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Stop a hung run
  initial begin
    #(64'd480_000_000);
    $display("FAIL fat12_fat16_table_engine");
    $finish;
  end

  // ---------------------------------------------------------------- shadow
  function automatic int unsigned ent_off(int unsigned c);
    return fat16 ? c * 2 : c + (c >> 1);
  endfunction

  function automatic bit cl_ok(int unsigned c);
    return c >= 2 && c <= ncl + 1 && ent_off(c) + 1 < TABLE_BYTES;
  endfunction

  function automatic bit at_end(int unsigned v);
    return fat16 ? (v >= EOC_MIN16) : (v >= EOC_MIN12);
  endfunction

  function automatic int unsigned get_ent(int unsigned c);
    int unsigned off;
    int unsigned w;
    off = ent_off(c);
    w   = {fat_shadow[off + 1], fat_shadow[off]};
    if (fat16) return w;
    return c[0] ? (w >> 4) : (w & 32'hFFF);
  endfunction

  function automatic void put_ent(int unsigned c, int unsigned v);
    int unsigned off;
    int unsigned w;
    off = ent_off(c);
    if (fat16) begin
      fat_shadow[off]     = v[7:0];
      fat_shadow[off + 1] = v[15:8];
    end else begin
      w = v & 32'hFFF;
      if (c[0]) begin
        fat_shadow[off]     = {w[3:0], fat_shadow[off][3:0]};
        fat_shadow[off + 1] = w[11:4];
      end else begin
        fat_shadow[off]     = w[7:0];
        fat_shadow[off + 1] = {fat_shadow[off + 1][7:4], w[11:8]};
      end
    end
  endfunction

  // Apply one command to the shadow and return the result it must give
  function automatic out_item_t fat_apply(in_item_t cmd);
    out_item_t   r;
    int unsigned cl;
    int unsigned cur;
    int unsigned nxt;
    int unsigned cnt;
    int unsigned found;
    int unsigned i;
    r  = '0;
    cl = cmd.cluster;
    case (cmd.func)
      FN_READ: begin
        if (!cl_ok(cl)) r.status = ST_RANGE;
        else begin
          r.result_value = 16'(get_ent(cl));
          r.end_of_chain = at_end(get_ent(cl));
        end
      end
      FN_WRITE: begin
        if (!cl_ok(cl)) r.status = ST_RANGE;
        else put_ent(cl, cmd.entry_value);
      end
      FN_ALLOC: begin
        if (cl != 0 && !cl_ok(cl)) r.status = ST_RANGE;
        else begin
          found = 0;
          for (i = 2; i <= ncl + 1; i++) begin
            if (!cl_ok(i)) break;
            if (get_ent(i) == 0) begin
              found = i;
              break;
            end
          end
          if (found == 0) r.status = ST_NOFREE;
          else begin
            put_ent(found, fat16 ? EOC_SET16 : EOC_SET12);
            if (cl != 0) put_ent(cl, found);
            r.result_value = 16'(found);
          end
        end
      end
      default: begin
        // Walk the chain, zeroing each entry once its link is read
        cur = cl;
        cnt = 0;
        while (cur >= 2 && !at_end(cur)) begin
          if (!cl_ok(cur)) begin
            r.status = ST_RANGE;
            break;
          end
          if (cnt >= ncl) begin
            r.status = ST_LONG;
            break;
          end
          nxt = get_ent(cur);
          put_ent(cur, 0);
          cnt++;
          cur = nxt;
        end
        r.result_value = 16'(cnt);
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------- checking
  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("mismatch %0s: got %h, expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        report("result with no command waiting", result_o.result_value, 'x);
      end else begin
        want = pending_res.pop_front();
        if (result_o.result_value !== want.result_value)
          report("result_value", result_o.result_value, want.result_value);
        if (result_o.end_of_chain !== want.end_of_chain)
          report("end_of_chain", result_o.end_of_chain, want.end_of_chain);
        if (result_o.status !== want.status)
          report("status", result_o.status, want.status);
      end
    end
  end

  // ---------------------------------------------------------------- driving
  // Drop start and hold until every item has come back and busy is low
  task automatic wait_idle();
    start = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FAT_TYPE) fat16 = data[0];
    else ncl = data;
  endtask

  // Set both registers; upper bits of the format write are noise
  task automatic configure(bit fat, int unsigned cc);
    load_reg(CFG_FAT_TYPE, {11'($urandom()), fat});
    load_reg(CFG_CLUSTERS, CFG_W'(cc));
    chain_head = '0;
    chain_tail = '0;
  endtask

  // Send one item; predict its result at the edge that accepts it
  task automatic send_cmd(logic [FUNC_W-1:0] func, logic [CL_W-1:0] cl,
                          logic [VAL_W-1:0] val, output out_item_t want);
    in_item_t cmd;
    cmd.func        = func;
    cmd.cluster     = cl;
    cmd.entry_value = val;
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    start = 1'b1;
    in_i  = cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = fat_apply(cmd);
    pending_res.push_back(want);
    @(negedge clk_i);
  endtask

  // -------------------------------------------------------------- stimulus
  function automatic logic [CL_W-1:0] pick_cluster(int unsigned valid_pct);
    if (ncl != 0 && $urandom_range(99) < valid_pct)
      return CL_W'($urandom_range(2, ncl + 1));
    return CL_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return fat16 ? {4'b0, pick_cluster(100)} : {4'($urandom()), pick_cluster(100)};
    if (sel < 55) begin
      if (fat16) return 16'($urandom_range(32'hFFF8, 32'hFFFF));
      return {4'($urandom()), 12'($urandom_range(32'hFF8, 32'hFFF))};
    end
    if (sel < 65) return '0;
    return 16'($urandom());
  endfunction

  // Half chain building and chain freeing, half plain entry access
  function automatic in_item_t next_cmd();
    in_item_t    cmd;
    int unsigned sel;
    int unsigned p;
    sel             = $urandom_range(99);
    p               = $urandom_range(99);
    cmd.entry_value = 16'($urandom());
    if (sel < 30) begin
      cmd.func    = FN_ALLOC;
      cmd.cluster = (p < 55) ? chain_tail : (p < 80) ? '0 : pick_cluster(50);
    end else if (sel < 50) begin
      cmd.func    = FN_FREE;
      cmd.cluster = (p < 60) ? chain_head : pick_cluster(50);
    end else if (sel < 75) begin
      cmd.func        = FN_WRITE;
      cmd.cluster     = pick_cluster(85);
      cmd.entry_value = pick_value();
    end else begin
      cmd.func    = FN_READ;
      cmd.cluster = pick_cluster(85);
    end
    return cmd;
  endfunction

  task automatic run_mix(int unsigned n);
    in_item_t    cmd;
    out_item_t   want;
    int unsigned hold_at;
    int unsigned k;
    hold_at = $urandom_range(n / 4, 3 * n / 4);
    for (k = 0; k < n; k++) begin
      // Pause the sender once until the block has caught up
      if (k == hold_at) wait_idle();
      cmd = next_cmd();
      send_cmd(cmd.func, cmd.cluster, cmd.entry_value, want);
      // Track the chain being built so later items extend or free it
      if (cmd.func == FN_ALLOC && want.status == ST_OK) begin
        if (cmd.cluster == 0) chain_head = want.result_value[CL_W-1:0];
        chain_tail = want.result_value[CL_W-1:0];
      end
      if (cmd.func == FN_FREE && cmd.cluster == chain_head) begin
        chain_head = '0;
        chain_tail = '0;
      end
    end
    wait_idle();
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_directed();
    out_item_t want;
    // Empty table straight after reset
    send_cmd(FN_READ,  12'd2, 16'h0000, want);
    send_cmd(FN_ALLOC, 12'd0, 16'hFFFF, want);
    send_cmd(FN_FREE,  12'd2, 16'h0000, want);
    // FAT12 packing of neighbouring odd and even entries, value truncation
    configure(1'b0, 5);
    send_cmd(FN_WRITE, 12'd2, 16'hFFFF, want);
    send_cmd(FN_WRITE, 12'd3, 16'hA5A5, want);
    send_cmd(FN_READ,  12'd2, 16'h0000, want);
    send_cmd(FN_READ,  12'd3, 16'hFFFF, want);
    send_cmd(FN_WRITE, 12'd4, 16'h0FF7, want);
    send_cmd(FN_READ,  12'd4, 16'h0000, want);
    // Clusters outside the table
    send_cmd(FN_READ,  12'd7,    16'h0000, want);
    send_cmd(FN_WRITE, 12'hFFF,  16'h1234, want);
    // Allocate: bad predecessor, fresh chain, linked, then table full
    send_cmd(FN_ALLOC, 12'd7, 16'h0000, want);
    send_cmd(FN_ALLOC, 12'd0, 16'h0000, want);
    send_cmd(FN_ALLOC, 12'd5, 16'h0000, want);
    send_cmd(FN_ALLOC, 12'd0, 16'h0000, want);
    // Free: normal chain, start already at end of chain, link out of range
    send_cmd(FN_FREE,  12'd5,   16'h0000, want);
    send_cmd(FN_FREE,  12'hFFF, 16'h0000, want);
    send_cmd(FN_WRITE, 12'd3,   16'h0009, want);
    send_cmd(FN_FREE,  12'd3,   16'h0000, want);
    // Self loop runs into the step cap
    configure(1'b0, 1);
    send_cmd(FN_WRITE, 12'd2, 16'h0002, want);
    send_cmd(FN_FREE,  12'd2, 16'h0000, want);
    // FAT16 end-of-chain threshold at both ends of the table
    configure(1'b1, 4094);
    send_cmd(FN_WRITE, 12'hFFF, 16'hFFF8, want);
    send_cmd(FN_READ,  12'hFFF, 16'h0000, want);
    send_cmd(FN_WRITE, 12'd2,   16'hFFF7, want);
    send_cmd(FN_READ,  12'd2,   16'h0000, want);
    wait_idle();
  endtask

  task automatic test_fat12_chains();
    repeat (3) begin
      configure(1'b0, $urandom_range(4, 48));
      run_mix(200);
    end
  endtask

  task automatic test_fat16_chains();
    repeat (3) begin
      configure(1'b1, $urandom_range(4, 48));
      run_mix(200);
    end
  endtask

  // Back-to-back items with no sender gaps
  task automatic test_steady_stream();
    idle_pct = 0;
    configure(1'b0, 16);
    run_mix(150);
    configure(1'b1, 3);
    run_mix(150);
    idle_pct = 17;
  endtask

  task automatic test_tiny_tables();
    int unsigned cc;
    for (cc = 0; cc < 3; cc++) begin
      configure(1'b0, cc);
      run_mix(25);
      configure(1'b1, cc);
      run_mix(25);
    end
  endtask

  task automatic test_large_tables();
    configure(1'b0, 4094);
    run_mix(150);
    configure(1'b1, 4094);
    run_mix(150);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    fat16        = 1'b0;
    ncl          = 0;
    mismatch_cnt = 0;
    idle_pct     = 17;
    chain_head   = '0;
    chain_tail   = '0;
    foreach (fat_shadow[i]) fat_shadow[i] = 8'h00;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fat12_chains();
    test_fat16_chains();
    test_steady_stream();
    test_tiny_tables();
    test_large_tables();

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASS fat12_fat16_table_engine");
    end else begin
      $display("FAIL fat12_fat16_table_engine");
    end
    $finish;
  end

endmodule
